### src/assert_macros.svh
// Assertion macros shared by the downscaler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off while reset is held.
`define BIDS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same-cycle implication.
`define BIDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    `BIDS_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

### src/bids_pkg.sv
// Package of the bilinear image downscaler: widths, config types, job record.
// No dependencies; imported by every module of the block.
package bids_pkg;

    localparam int COMP_W   = 8;
    localparam int PIX_W    = 3 * COMP_W;
    localparam int WGT_W    = 8;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int COL_MAX  = (1 << COL_W) - 1;
    localparam int ROW_MAX  = (1 << ROW_W) - 1;
    localparam int COLPOS_W = 27;
    localparam int ROWPOS_W = 28;

    localparam int SW_W   = 12;
    localparam int SH_W   = 13;
    localparam int DW_W   = 12;
    localparam int DH_W   = 13;
    localparam int STEP_W = 23;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = STEP_W;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int FRAC_BITS_DEF = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [SW_W-1:0]   SRC_WIDTH_RST  = SW_W'(640);
    localparam logic [SH_W-1:0]   SRC_HEIGHT_RST = SH_W'(480);
    localparam logic [DW_W-1:0]   DST_WIDTH_RST  = DW_W'(213);
    localparam logic [DH_W-1:0]   DST_HEIGHT_RST = DH_W'(160);
    localparam logic [STEP_W-1:0] STEP_RST       = STEP_W'(196608);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_STEP       = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [SW_W-1:0]   src_width;
        logic [SH_W-1:0]   src_height;
        logic [DW_W-1:0]   dst_width;
        logic [DH_W-1:0]   dst_height;
        logic [STEP_W-1:0] step;
    } cfg_t;

    // One destination pixel job: four neighbours, weights, what to emit.
    typedef struct packed {
        logic [PIX_W-1:0] ul;
        logic [PIX_W-1:0] ur;
        logic [PIX_W-1:0] dl;
        logic [PIX_W-1:0] dr;
        logic [WGT_W-1:0] wx;
        logic [WGT_W-1:0] wy;
        logic             mode_h;
        logic             emit_main;
        logic             emit_last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row_main;
        logic [ROW_W-1:0] row_last;
    } job_t;

endpackage

### src/bilinear_image_downscaler_top.sv
// Top level of the bilinear image downscaler: config registers and the
// front end, job queue and blend back end. Depends on bids_pkg.
//
// Source pixels enter in raster order on s_valid/s_ready, one beat per pixel.
// Destination pixels leave on m_valid/m_ready with their column and row;
// m_end_of_run marks the last result caused by one source beat.
// A beat is taken every cycle while the four-entry job queue has room.
// A result passes through front stage B, the job queue, blend stages 1 and 2
// and the output register. A beat that closes both a middle row and the last
// row brings two results, sent one after the other; the queue absorbs that.
// When the receiver stalls, results wait in the output register, the queue
// fills and s_ready drops until room frees up.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_wr_index
// (source width, source height, dest width, dest height, scale step); write
// only while idle. Reset clears all counters and positions and loads the
// default sizes; the line store is not cleared, each row is written before
// it is read.
module bilinear_image_downscaler_top
    import bids_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COMP_W-1:0]     s_first_component,
    input  logic [COMP_W-1:0]     s_second_component,
    input  logic [COMP_W-1:0]     s_third_component,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COMP_W-1:0]     m_out_first,
    output logic [COMP_W-1:0]     m_out_second,
    output logic [COMP_W-1:0]     m_out_third,
    output logic [COL_W-1:0]      m_dest_column,
    output logic [ROW_W-1:0]      m_dest_row,
    output logic                  m_end_of_run
);

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_full, q_valid, q_pop;
    job_t q_in_job, q_out_job;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SRC_WIDTH:  cfg_next.src_width  = cfg_wr_data[SW_W-1:0];
                CFG_SRC_HEIGHT: cfg_next.src_height = cfg_wr_data[SH_W-1:0];
                CFG_DST_WIDTH:  cfg_next.dst_width  = cfg_wr_data[DW_W-1:0];
                CFG_DST_HEIGHT: cfg_next.dst_height = cfg_wr_data[DH_W-1:0];
                CFG_STEP:       cfg_next.step       = cfg_wr_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width  <= SRC_WIDTH_RST;
            cfg_reg.src_height <= SRC_HEIGHT_RST;
            cfg_reg.dst_width  <= DST_WIDTH_RST;
            cfg_reg.dst_height <= DST_HEIGHT_RST;
            cfg_reg.step       <= STEP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bids_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_i              (cfg_reg),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_component  (s_first_component),
        .s_second_component (s_second_component),
        .s_third_component  (s_third_component),
        .q_push_o           (q_push),
        .q_job_o            (q_in_job),
        .q_full_i           (q_full)
    );

    bids_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (q_push),
        .job_i   (q_in_job),
        .full_o  (q_full),
        .valid_o (q_valid),
        .pop_i   (q_pop),
        .job_o   (q_out_job)
    );

    bids_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid_i     (q_valid),
        .q_job_i       (q_out_job),
        .q_pop_o       (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_first   (m_out_first),
        .m_out_second  (m_out_second),
        .m_out_third   (m_out_third),
        .m_dest_column (m_dest_column),
        .m_dest_row    (m_dest_row),
        .m_end_of_run  (m_end_of_run)
    );

endmodule

### src/bids_front.sv
// Front end: accepts source beats, keeps the line store and positions,
// and classifies each beat into a blend job. Depends on bids_pkg.
`include "assert_macros.svh"

module bids_front
    import bids_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg_i,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [COMP_W-1:0] s_first_component,
    input  logic [COMP_W-1:0] s_second_component,
    input  logic [COMP_W-1:0] s_third_component,
    output logic              q_push_o,
    output job_t              q_job_o,
    input  logic              q_full_i
);

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int IX_W   = COLPOS_W - FRAC_BITS;
    localparam int IY_W   = ROWPOS_W - FRAC_BITS;
    localparam int XW     = ((IX_W > COL_W) ? IX_W : COL_W) + 1;
    localparam int YW     = ((IY_W > ROW_W) ? IY_W : ROW_W) + 1;
    localparam int LC_CAP = (MAX_WIDTH - 1 < COL_MAX) ? MAX_WIDTH - 1 : COL_MAX;

    typedef struct packed {
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] lpix;
        logic             sel_left;
        logic [WGT_W-1:0] wx;
        logic [WGT_W-1:0] wy;
        logic             mode_h;
        logic             emit_main;
        logic             emit_last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row_main;
        logic [ROW_W-1:0] row_last;
    } stage_t;

    logic [PIX_W-1:0] mem [MAX_WIDTH];

    logic [COL_W-1:0]    s_cnt_reg,   s_cnt_next;
    logic [ROW_W-1:0]    row_cnt_reg, row_cnt_next;
    logic [ROW_W-1:0]    drow_reg,    drow_next;
    logic [COL_W-1:0]    dcol_reg,    dcol_next;
    logic [COLPOS_W-1:0] colpos_reg,  colpos_next;
    logic [ROWPOS_W-1:0] rowpos_reg,  rowpos_next;
    logic [PIX_W-1:0]    lcur_reg;
    logic [PIX_W-1:0]    above_reg;
    logic [PIX_W-1:0]    lab_reg;
    logic                b_valid_reg, b_valid_next;
    stage_t              b_reg,       b_next;

    logic [PIX_W-1:0] cur;
    logic             accept;
    logic [SW_W-1:0]  sw_m1;
    logic [SH_W-1:0]  sh_m1;
    logic [DH_W-1:0]  dh_m1;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic [IX_W-1:0]  ix;
    logic [IY_W-1:0]  iy;
    logic [WGT_W-1:0] wx_raw, wx;
    logic [WGT_W-1:0] wy;
    logic [YW-1:0]    iy_p1, target;
    logic [XW-1:0]    trig;
    logic             main_ok, main_here, last_here, col_ok, sel_left, hit, mode_h;
    logic             b_emit, b_go;

    assign cur    = {s_third_component, s_second_component, s_first_component};
    assign ix     = colpos_reg[COLPOS_W-1:FRAC_BITS];
    assign iy     = rowpos_reg[ROWPOS_W-1:FRAC_BITS];
    assign wx_raw = colpos_reg[FRAC_BITS-1 -: WGT_W];
    assign wy     = rowpos_reg[FRAC_BITS-1 -: WGT_W];

    // frame limits from config
    always_comb begin
        sw_m1    = (cfg_i.src_width == '0) ? '0 : cfg_i.src_width - 1'b1;
        sh_m1    = (cfg_i.src_height == '0) ? '0 : cfg_i.src_height - 1'b1;
        dh_m1    = cfg_i.dst_height - 1'b1;
        last_col = (sw_m1 > SW_W'(LC_CAP)) ? COL_W'(LC_CAP) : sw_m1[COL_W-1:0];
        last_row = (sh_m1 > SH_W'(ROW_MAX)) ? ROW_W'(ROW_MAX) : sh_m1[ROW_W-1:0];
    end

    // classification of the beat against the destination pixel in progress
    always_comb begin
        main_ok = (DH_W'(drow_reg) < cfg_i.dst_height)
                  && ((drow_reg == '0) || ((DH_W'(drow_reg) + 1'b1) < cfg_i.dst_height));
        iy_p1   = YW'(iy) + 1'b1;
        if (drow_reg == '0) begin
            target = '0;
        end else if (iy_p1 > YW'(last_row)) begin
            target = YW'(last_row);
        end else begin
            target = iy_p1;
        end
        main_here = main_ok && (target == YW'(row_cnt_reg));
        last_here = (cfg_i.dst_height >= DH_W'(2)) && (row_cnt_reg == last_row);
        mode_h    = (drow_reg == '0) || (YW'(iy) >= YW'(last_row));
        col_ok    = DW_W'(dcol_reg) < cfg_i.dst_width;

        sel_left = 1'b0;
        wx       = wx_raw;
        if (XW'(ix) >= XW'(last_col)) begin
            // right edge clamp: last column serves both neighbours
            trig = XW'(last_col);
            wx   = '0;
        end else if (wx_raw == '0) begin
            trig = XW'(ix);
        end else begin
            trig     = XW'(ix) + 1'b1;
            sel_left = 1'b1;
        end
        hit = (main_here || last_here) && col_ok && (XW'(s_cnt_reg) == trig);
    end

    // stage B hand-off
    assign b_emit   = b_reg.emit_main | b_reg.emit_last;
    assign b_go     = b_valid_reg && (!b_emit || !q_full_i);
    assign s_ready  = !b_valid_reg || b_go;
    assign accept   = s_valid && s_ready;
    assign q_push_o = b_valid_reg && b_emit && !q_full_i;

    always_comb begin
        q_job_o.ul        = b_reg.sel_left ? lab_reg : above_reg;
        q_job_o.ur        = above_reg;
        q_job_o.dl        = b_reg.lpix;
        q_job_o.dr        = b_reg.cur;
        q_job_o.wx        = b_reg.wx;
        q_job_o.wy        = b_reg.wy;
        q_job_o.mode_h    = b_reg.mode_h;
        q_job_o.emit_main = b_reg.emit_main;
        q_job_o.emit_last = b_reg.emit_last;
        q_job_o.col       = b_reg.col;
        q_job_o.row_main  = b_reg.row_main;
        q_job_o.row_last  = b_reg.row_last;
    end

    // counter and position update per accepted beat
    always_comb begin
        s_cnt_next   = s_cnt_reg;
        row_cnt_next = row_cnt_reg;
        drow_next    = drow_reg;
        dcol_next    = dcol_reg;
        colpos_next  = colpos_reg;
        rowpos_next  = rowpos_reg;
        if (accept) begin
            if (hit) begin
                dcol_next   = dcol_reg + 1'b1;
                colpos_next = colpos_reg + COLPOS_W'(cfg_i.step);
            end
            if (s_cnt_reg >= last_col) begin
                s_cnt_next  = '0;
                dcol_next   = '0;
                colpos_next = '0;
                if (main_here) begin
                    drow_next   = drow_reg + 1'b1;
                    rowpos_next = rowpos_reg + ROWPOS_W'(cfg_i.step);
                end
                if (row_cnt_reg >= last_row) begin
                    row_cnt_next = '0;
                    drow_next    = '0;
                    rowpos_next  = '0;
                end else begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
            end else begin
                s_cnt_next = s_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        b_next       = b_reg;
        b_valid_next = b_valid_reg;
        if (accept) begin
            b_valid_next     = 1'b1;
            b_next.cur       = cur;
            b_next.lpix      = sel_left ? lcur_reg : cur;
            b_next.sel_left  = sel_left;
            b_next.wx        = wx;
            b_next.wy        = wy;
            b_next.mode_h    = mode_h;
            b_next.emit_main = main_here && hit;
            b_next.emit_last = last_here && hit;
            b_next.col       = dcol_reg;
            b_next.row_main  = drow_reg;
            b_next.row_last  = dh_m1[ROW_W-1:0];
        end else if (b_go) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_cnt_reg   <= '0;
            row_cnt_reg <= '0;
            drow_reg    <= '0;
            dcol_reg    <= '0;
            colpos_reg  <= '0;
            rowpos_reg  <= '0;
            lcur_reg    <= '0;
            lab_reg     <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            s_cnt_reg   <= s_cnt_next;
            row_cnt_reg <= row_cnt_next;
            drow_reg    <= drow_next;
            dcol_reg    <= dcol_next;
            colpos_reg  <= colpos_next;
            rowpos_reg  <= rowpos_next;
            b_valid_reg <= b_valid_next;
            if (accept) begin
                lcur_reg <= cur;
            end
            // previous beat's upper pixel becomes the upper-left neighbour
            if (b_go) begin
                lab_reg <= above_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        b_reg <= b_next;
    end

    // line store: read old entry, then overwrite with the current row
    always_ff @(posedge aclk) begin
        if (accept) begin
            above_reg              <= mem[AW'(s_cnt_reg)];
            mem[AW'(s_cnt_reg)]    <= cur;
        end
    end

    `BIDS_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn, !s_ready,
        q_full_i && b_valid_reg, "front stalled while job queue has room")

endmodule

### src/bids_queue.sv
// Short job queue between the front end and the blend back end.
// Depends on bids_pkg (job_t, Q_DEPTH).
`include "assert_macros.svh"

module bids_queue
    import bids_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_i,
    input  job_t job_i,
    output logic full_o,
    output logic valid_o,
    input  logic pop_i,
    output job_t job_o
);

    job_t               ent_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg,    cnt_next;
    logic               do_push, do_pop;

    assign full_o  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign valid_o = (cnt_reg != '0);
    assign job_o   = ent_reg[rd_ptr_reg];
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && valid_o;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= job_i;
        end
    end

    `BIDS_ASSERT(a_cnt_in_range, aclk, aresetn, cnt_reg <= Q_CNT_W'(Q_DEPTH),
        "job queue count beyond depth")
    `BIDS_ASSERT_IMP(a_ptrs_when_empty, aclk, aresetn, cnt_reg == '0,
        wr_ptr_reg == rd_ptr_reg, "queue pointers differ while empty")

endmodule

### src/bids_back.sv
// Back end: horizontal then vertical blend of queued jobs, and the output
// register that sends one or two result beats per job. Depends on bids_pkg.
`include "assert_macros.svh"

module bids_back
    import bids_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid_i,
    input  job_t              q_job_i,
    output logic              q_pop_o,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COMP_W-1:0] m_out_first,
    output logic [COMP_W-1:0] m_out_second,
    output logic [COMP_W-1:0] m_out_third,
    output logic [COL_W-1:0]  m_dest_column,
    output logic [ROW_W-1:0]  m_dest_row,
    output logic              m_end_of_run
);

    localparam int HS_W = 2 * COMP_W;
    localparam logic [WGT_W:0] WGT_ONE = (WGT_W + 1)'(1 << WGT_W);

    typedef struct packed {
        logic [2:0][HS_W-1:0] top;
        logic [2:0][HS_W-1:0] bot;
        logic [WGT_W-1:0]     wy;
        logic                 mode_h;
        logic                 emit_main;
        logic                 emit_last;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row_main;
        logic [ROW_W-1:0]     row_last;
    } s1_t;

    typedef struct packed {
        logic [PIX_W-1:0] v_main;
        logic [PIX_W-1:0] v_last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row_main;
        logic [ROW_W-1:0] row_last;
    } s2_t;

    function automatic logic [HS_W-1:0] hmix(input logic [COMP_W-1:0] a,
                                             input logic [COMP_W-1:0] b,
                                             input logic [WGT_W:0] wa,
                                             input logic [WGT_W:0] wb);
        logic [HS_W:0] pa;
        logic [HS_W:0] pb;
        logic [HS_W:0] sum;
        pa  = (HS_W + 1)'(a) * (HS_W + 1)'(wa);
        pb  = (HS_W + 1)'(b) * (HS_W + 1)'(wb);
        sum = pa + pb;
        return sum[HS_W-1:0];
    endfunction

    function automatic logic [COMP_W-1:0] vmix(input logic [HS_W-1:0] t,
                                               input logic [HS_W-1:0] b,
                                               input logic [WGT_W:0] wt,
                                               input logic [WGT_W:0] wb);
        logic [HS_W+WGT_W:0] pt;
        logic [HS_W+WGT_W:0] pb;
        logic [HS_W+WGT_W:0] sum;
        pt  = (HS_W + WGT_W + 1)'(t) * (HS_W + WGT_W + 1)'(wt);
        pb  = (HS_W + WGT_W + 1)'(b) * (HS_W + WGT_W + 1)'(wb);
        sum = pt + pb;
        return sum[HS_W+WGT_W-1 -: COMP_W];
    endfunction

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic pend_main_reg, pend_main_next;
    logic pend_last_reg, pend_last_next;

    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  m_pix_reg,   m_pix_next;
    logic [COL_W-1:0]  m_col_reg,   m_col_next;
    logic [ROW_W-1:0]  m_row_reg,   m_row_next;
    logic              m_eor_reg,   m_eor_next;

    logic out_load, last_beat, s2_done, s2_take;

    assign out_load  = s2_valid_reg && (!m_valid_reg || m_ready);
    assign last_beat = !(pend_main_reg && pend_last_reg);
    assign s2_done   = out_load && last_beat;
    assign s2_take   = s1_valid_reg && (!s2_valid_reg || s2_done);
    assign q_pop_o   = q_valid_i && (!s1_valid_reg || s2_take);

    // stage 1: horizontal blends of the upper and lower pairs
    always_comb begin
        logic [WGT_W:0] wa;
        logic [WGT_W:0] wb;
        wa = WGT_ONE - {1'b0, q_job_i.wx};
        wb = {1'b0, q_job_i.wx};
        s1_next = s1_reg;
        for (int k = 0; k < 3; k++) begin
            s1_next.top[k] = hmix(q_job_i.ul[COMP_W*k +: COMP_W],
                                  q_job_i.ur[COMP_W*k +: COMP_W], wa, wb);
            s1_next.bot[k] = hmix(q_job_i.dl[COMP_W*k +: COMP_W],
                                  q_job_i.dr[COMP_W*k +: COMP_W], wa, wb);
        end
        s1_next.wy        = q_job_i.wy;
        s1_next.mode_h    = q_job_i.mode_h;
        s1_next.emit_main = q_job_i.emit_main;
        s1_next.emit_last = q_job_i.emit_last;
        s1_next.col       = q_job_i.col;
        s1_next.row_main  = q_job_i.row_main;
        s1_next.row_last  = q_job_i.row_last;
        s1_valid_next     = q_pop_o ? 1'b1 : (s2_take ? 1'b0 : s1_valid_reg);
    end

    // stage 2: vertical blend; single-row results take the lower pair alone
    always_comb begin
        logic [WGT_W:0] wt;
        logic [WGT_W:0] wb;
        wt = WGT_ONE - {1'b0, s1_reg.wy};
        wb = {1'b0, s1_reg.wy};
        s2_next = s2_reg;
        for (int k = 0; k < 3; k++) begin
            s2_next.v_last[COMP_W*k +: COMP_W] = s1_reg.bot[k][HS_W-1 -: COMP_W];
            s2_next.v_main[COMP_W*k +: COMP_W] = s1_reg.mode_h
                ? s1_reg.bot[k][HS_W-1 -: COMP_W]
                : vmix(s1_reg.top[k], s1_reg.bot[k], wt, wb);
        end
        s2_next.col      = s1_reg.col;
        s2_next.row_main = s1_reg.row_main;
        s2_next.row_last = s1_reg.row_last;

        s2_valid_next  = s2_valid_reg;
        pend_main_next = pend_main_reg;
        pend_last_next = pend_last_reg;
        if (s2_take) begin
            s2_valid_next  = 1'b1;
            pend_main_next = s1_reg.emit_main;
            pend_last_next = s1_reg.emit_last;
        end else if (s2_done) begin
            s2_valid_next  = 1'b0;
            pend_main_next = 1'b0;
            pend_last_next = 1'b0;
        end else if (out_load) begin
            pend_main_next = 1'b0;
        end
    end

    // output register: middle-row result first, last-row result second
    always_comb begin
        m_valid_next = m_valid_reg;
        m_pix_next   = m_pix_reg;
        m_col_next   = m_col_reg;
        m_row_next   = m_row_reg;
        m_eor_next   = m_eor_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_pix_next   = pend_main_reg ? s2_reg.v_main : s2_reg.v_last;
            m_col_next   = s2_reg.col;
            m_row_next   = pend_main_reg ? s2_reg.row_main : s2_reg.row_last;
            m_eor_next   = last_beat;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            pend_main_reg <= 1'b0;
            pend_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            pend_main_reg <= pend_main_next;
            pend_last_reg <= pend_last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop_o) begin
            s1_reg <= s1_next;
        end
        if (s2_take) begin
            s2_reg <= s2_next;
        end
        m_pix_reg <= m_pix_next;
        m_col_reg <= m_col_next;
        m_row_reg <= m_row_next;
        m_eor_reg <= m_eor_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_first   = m_pix_reg[0 +: COMP_W];
    assign m_out_second  = m_pix_reg[COMP_W +: COMP_W];
    assign m_out_third   = m_pix_reg[2*COMP_W +: COMP_W];
    assign m_dest_column = m_col_reg;
    assign m_dest_row    = m_row_reg;
    assign m_end_of_run  = m_eor_reg;

    `BIDS_ASSERT_IMP(a_s2_has_work, aclk, aresetn, s2_valid_reg,
        pend_main_reg || pend_last_reg, "blend stage holds a job with nothing to send")

endmodule

### test/bilinear_image_downscaler_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bilinear_image_downscaler_top: a bit-exact predictor
// of the scaler feeds a scoreboard of expected destination pixels.
// Depends on bids_pkg and the downscaler RTL; needs nothing else.

import bids_pkg::*;

typedef struct packed {
    logic [COMP_W-1:0] c_first;
    logic [COMP_W-1:0] c_second;
    logic [COMP_W-1:0] c_third;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              eor;
} dest_pixel_t;

class downscale_checker;
    logic [PIX_W-1:0]    line_buf [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]    left_cur, left_above;
    logic [COL_W-1:0]    src_col, dst_col;
    logic [ROW_W-1:0]    src_row, dst_row;
    logic [COLPOS_W-1:0] col_pos;
    logic [ROWPOS_W-1:0] row_pos;
    logic [SW_W-1:0]     src_width;
    logic [SH_W-1:0]     src_height;
    logic [DW_W-1:0]     dst_width;
    logic [DH_W-1:0]     dst_height;
    logic [STEP_W-1:0]   step;
    dest_pixel_t         expected_pixels [$];
    int                  beats, checked, double_beats, errors;

    function new();
        foreach (line_buf[i]) line_buf[i] = '0;
        left_cur     = '0;
        left_above   = '0;
        src_col      = '0;
        dst_col      = '0;
        src_row      = '0;
        dst_row      = '0;
        col_pos      = '0;
        row_pos      = '0;
        src_width    = SRC_WIDTH_RST;
        src_height   = SRC_HEIGHT_RST;
        dst_width    = DST_WIDTH_RST;
        dst_height   = DST_HEIGHT_RST;
        step         = STEP_RST;
        beats        = 0;
        checked      = 0;
        double_beats = 0;
        errors       = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SRC_WIDTH:  src_width  = val[SW_W-1:0];
            CFG_SRC_HEIGHT: src_height = val[SH_W-1:0];
            CFG_DST_WIDTH:  dst_width  = val[DW_W-1:0];
            CFG_DST_HEIGHT: dst_height = val[DH_W-1:0];
            CFG_STEP:       step       = val[STEP_W-1:0];
            default: ;
        endcase
    endfunction

    function int last_col();
        int lc;
        lc = (src_width == 0) ? 0 : int'(src_width) - 1;
        if (lc > COL_MAX) lc = COL_MAX;
        if (lc > MAX_WIDTH_DEF - 1) lc = MAX_WIDTH_DEF - 1;
        return lc;
    endfunction

    function int last_row();
        int lr;
        lr = (src_height == 0) ? 0 : int'(src_height) - 1;
        if (lr > ROW_MAX) lr = ROW_MAX;
        return lr;
    endfunction

    function int frame_beats();
        return (last_col() + 1) * (last_row() + 1);
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    function logic [PIX_W-1:0] blend_row(logic [PIX_W-1:0] l, logic [PIX_W-1:0] r, int wx);
        logic [PIX_W-1:0] v;
        int a, b;
        for (int k = 0; k < 3; k++) begin
            a = l[COMP_W*k +: COMP_W];
            b = r[COMP_W*k +: COMP_W];
            v[COMP_W*k +: COMP_W] = COMP_W'((a * (256 - wx) + b * wx) >> 8);
        end
        return v;
    endfunction

    function logic [PIX_W-1:0] blend_quad(logic [PIX_W-1:0] ul, logic [PIX_W-1:0] ur,
                                          logic [PIX_W-1:0] dl, logic [PIX_W-1:0] dr,
                                          int wx, int wy);
        logic [PIX_W-1:0] v;
        int sum;
        for (int k = 0; k < 3; k++) begin
            sum = int'(ul[COMP_W*k +: COMP_W]) * (256 - wx) * (256 - wy)
                + int'(ur[COMP_W*k +: COMP_W]) * wx * (256 - wy)
                + int'(dl[COMP_W*k +: COMP_W]) * (256 - wx) * wy
                + int'(dr[COMP_W*k +: COMP_W]) * wx * wy;
            v[COMP_W*k +: COMP_W] = COMP_W'(sum >> 16);
        end
        return v;
    endfunction

    function dest_pixel_t make_pixel(logic [PIX_W-1:0] pix, logic [COL_W-1:0] col, int row);
        dest_pixel_t p;
        p.c_first  = pix[7:0];
        p.c_second = pix[15:8];
        p.c_third  = pix[23:16];
        p.col      = col;
        p.row      = ROW_W'(row);
        p.eor      = 1'b0;
        return p;
    endfunction

    // Advance the scaler by one source beat and queue the destination pixels it yields.
    function void note_source_beat(logic [COMP_W-1:0] c0, logic [COMP_W-1:0] c1,
                                   logic [COMP_W-1:0] c2);
        logic [PIX_W-1:0] cur, above, lft, rgt, up_l, up_r, pix;
        int s, row, r, lc, lr, dw, dh, iy, wy, ix, wx, target, trig;
        bit main_here, last_here;
        dest_pixel_t made [$];
        s   = src_col;
        row = src_row;
        r   = dst_row;
        dw  = dst_width;
        dh  = dst_height;
        cur = {c2, c1, c0};
        above = line_buf[s];
        line_buf[s] = cur;
        lc = last_col();
        lr = last_row();
        iy = int'(row_pos >> FRAC_BITS_DEF);
        wy = int'(row_pos[FRAC_BITS_DEF-1 -: WGT_W]);

        main_here = 1'b0;
        if (r < dh && (r == 0 || r + 1 < dh)) begin
            target = 0;
            if (r != 0) begin
                target = iy + 1;
                if (target > lr) target = lr;
            end
            main_here = (target == row);
        end
        last_here = (dh >= 2 && row == lr);

        if ((main_here || last_here) && int'(dst_col) < dw) begin
            ix   = int'(col_pos >> FRAC_BITS_DEF);
            wx   = int'(col_pos[FRAC_BITS_DEF-1 -: WGT_W]);
            lft  = cur;
            rgt  = cur;
            up_l = above;
            up_r = above;
            if (ix >= lc) begin
                // right edge: last column serves as both neighbours
                trig = lc;
                wx   = 0;
            end else if (wx == 0) begin
                trig = ix;
            end else begin
                trig = ix + 1;
                lft  = left_cur;
                up_l = left_above;
            end
            if (s == trig) begin
                if (main_here) begin
                    if (r == 0 || iy >= lr) pix = blend_row(lft, rgt, wx);
                    else pix = blend_quad(up_l, up_r, lft, rgt, wx, wy);
                    made.push_back(make_pixel(pix, dst_col, r));
                end
                if (last_here)
                    made.push_back(make_pixel(blend_row(lft, rgt, wx), dst_col, dh - 1));
                dst_col = dst_col + 1'b1;
                col_pos = col_pos + COLPOS_W'(step);
            end
        end

        left_cur   = cur;
        left_above = above;

        if (s >= lc) begin
            src_col = '0;
            dst_col = '0;
            col_pos = '0;
            if (main_here) begin
                dst_row = dst_row + 1'b1;
                row_pos = row_pos + ROWPOS_W'(step);
            end
            if (row >= lr) begin
                src_row = '0;
                dst_row = '0;
                row_pos = '0;
            end else begin
                src_row = src_row + 1'b1;
            end
        end else begin
            src_col = src_col + 1'b1;
        end

        if (made.size() > 0) made[made.size()-1].eor = 1'b1;
        if (made.size() > 1) double_beats++;
        foreach (made[i]) expected_pixels.push_back(made[i]);
        beats++;
    endfunction

    function void check_dest_pixel(dest_pixel_t got);
        dest_pixel_t want;
        if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected dest pixel col %0d row %0d: %02h %02h %02h eor %0d",
                         got.col, got.row, got.c_first, got.c_second, got.c_third, got.eor);
            return;
        end
        want = expected_pixels.pop_front();
        checked++;
        if (got != want) begin
            errors++;
            if (errors <= 10) begin
                $display("dest pixel mismatch: expected %02h %02h %02h col %0d row %0d eor %0d",
                         want.c_first, want.c_second, want.c_third, want.col, want.row,
                         want.eor);
                $display("                     got      %02h %02h %02h col %0d row %0d eor %0d",
                         got.c_first, got.c_second, got.c_third, got.col, got.row,
                         got.eor);
            end
        end
    endfunction
endclass

module bilinear_image_downscaler_top_tb;

    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 160;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [COMP_W-1:0]     s_first_component;
    logic [COMP_W-1:0]     s_second_component;
    logic [COMP_W-1:0]     s_third_component;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COMP_W-1:0]     m_out_first;
    logic [COMP_W-1:0]     m_out_second;
    logic [COMP_W-1:0]     m_out_third;
    logic [COL_W-1:0]      m_dest_column;
    logic [ROW_W-1:0]      m_dest_row;
    logic                  m_end_of_run;

    downscale_checker sb = new();
    dest_pixel_t      seen;
    bit               no_idle = 1'b0;
    int               stall_cycles = 0;
    int               settings_run = 0;

    bilinear_image_downscaler_top i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_component  (s_first_component),
        .s_second_component (s_second_component),
        .s_third_component  (s_third_component),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_first        (m_out_first),
        .m_out_second       (m_out_second),
        .m_out_third        (m_out_third),
        .m_dest_column      (m_dest_column),
        .m_dest_row         (m_dest_row),
        .m_end_of_run       (m_end_of_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 21);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.c_first  = m_out_first;
            seen.c_second = m_out_second;
            seen.c_third  = m_out_third;
            seen.col      = m_dest_column;
            seen.row      = m_dest_row;
            seen.eor      = m_end_of_run;
            sb.check_dest_pixel(seen);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d pixels outstanding",
                     stall_cycles, sb.pending());
            $display("bilinear_image_downscaler_top_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] corner_pixel(int i);
        case (i % 6)
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h00FF00;
            3: return 24'hAA55AA;
            4: return 24'h55AA55;
            default: return 24'hFF00FF;
        endcase
    endfunction

    // Called at a falling edge; returns at a falling edge with s_valid still high.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while (!no_idle && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_first_component  <= pix[7:0];
        s_second_component <= pix[15:8];
        s_third_component  <= pix[23:16];
        do @(posedge aclk); while (!s_ready);
        sb.note_source_beat(pix[7:0], pix[15:8], pix[23:16]);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= CFG_DATA_W'(val);
        sb.set_reg(idx, CFG_DATA_W'(val));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        // beats that yield nothing may still be in the pipe
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Reprogram while idle, then stream whole frames so every line store read
    // hits a row written earlier in the same frame.
    task automatic run_frames(input int sw, input int sh, input int dw, input int dh,
                              input int stp, input int frames, input bit corners,
                              output int sent);
        logic [PIX_W-1:0] pix;
        wait_idle();
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        write_reg(CFG_STEP, stp);
        cfg_wr_en <= 1'b0;
        settings_run++;
        sent = frames * sb.frame_beats();
        for (int i = 0; i < sent; i++) begin
            pix = corners ? corner_pixel(i) : PIX_W'($urandom);
            send_pixel(pix);
        end
    endtask

    initial begin
        int sw, sh, dw, dh, stp, frames, pick, sent, random_beats;
        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_index       = '0;
        cfg_wr_data        = '0;
        s_valid            = 1'b0;
        s_first_component  = '0;
        s_second_component = '0;
        s_third_component  = '0;
        random_beats       = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 4x3 at step 1.5: fractional weights, right clamp, a dropped column,
        // and a middle row landing on the last source row (two results per beat)
        run_frames(4, 3, 4, 3, 32'h18000, 2, 1'b1, sent);

        // long rows at unit step, no idling on either side
        no_idle = 1'b1;
        run_frames(128, 2, 128, 1, 65536, 1, 1'b0, sent);
        no_idle = 1'b0;

        while (random_beats < RANDOM_BEATS) begin
            sw   = $urandom_range(2, 16);
            sh   = $urandom_range(2, 8);
            pick = $urandom_range(99);
            if (pick < 15)      stp = int'($urandom_range(1, 4)) << 16;
            else if (pick < 88) stp = $urandom_range(65536, 262144);
            else if (pick < 94) stp = $urandom_range(0, 65535);
            else                stp = $urandom_range(262144, 4194304);
            dw = (stp == 0) ? 1 : ((sw - 1) * 65536) / stp + 1;
            dh = (stp == 0) ? 1 : ((sh - 1) * 65536) / stp + 1;
            dw = dw + int'($urandom_range(0, 2)) - 1;
            dh = dh + int'($urandom_range(0, 3)) - 1;
            if ($urandom_range(19) == 0) dw = 0;
            if ($urandom_range(19) == 0) dh = 0;
            if ($urandom_range(24) == 0) sw = 0;
            if ($urandom_range(24) == 0) sh = 0;
            frames = $urandom_range(1, 2);
            run_frames(sw, sh, dw, dh, stp, frames, 1'b0, sent);
            random_beats += sent;
        end

        run_frames(40, 4, 4, 3, 4194304, 1, 1'b0, sent);
        run_frames(40, 3, 4, 3, 32'h7FFFFF, 1, 1'b0, sent);
        run_frames(0, 5, 3, 3, 65536, 2, 1'b0, sent);
        run_frames(20, 0, 5, 2, 196608, 1, 1'b0, sent);
        run_frames(6, 4, 0, 0, 65536, 1, 1'b0, sent);
        run_frames(6, 4, 5, 4, 0, 1, 1'b0, sent);

        wait_idle();
        $display("%0d source beats over %0d size settings, %0d destination pixels checked",
                 sb.beats, settings_run, sb.checked);
        $display("%0d beats closed a middle row and the last row together, %0d mismatches",
                 sb.double_beats, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("bilinear_image_downscaler_top_tb OK");
        end else begin
            $display("bilinear_image_downscaler_top_tb NOT OK");
        end
        $finish;
    end

endmodule
